FILE: rtl/lcfi_pkg.sv
// Shared types, constants and helpers for the lossy counting frequent-item table.
// Used by lcfi_div, lcfi_cell and lossy_counting_frequent_items.
package lcfi_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int MAX_RESULTS = 64;
  localparam int KEY_W = 64;
  localparam int CNT_W = 48;
  localparam int DIV_W = 32;
  localparam logic [DIV_W-1:0] WINDOW_RESET = 32'd1000;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [2:0] ST_UPDATED = 3'd0;
  localparam logic [2:0] ST_ADMITTED = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_REPORT = 3'd4;

  typedef enum logic {
    MODE_LOOKUP = 1'b0,
    MODE_SELECT = 1'b1
  } mode_t;

  typedef struct packed {
    logic act;
    mode_t mode;
    logic found;
    logic free_seen;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
    logic [IDX_W-1:0] idx;
  } tok_t;

  typedef struct packed {
    logic clr;
    logic wr_hit;
    logic wr_new;
    logic prune;
    logic take;
    logic [KEY_W-1:0] wkey;
    logic [CNT_W-1:0] wcnt;
    logic [DIV_W-1:0] delta;
    logic [IDX_W-1:0] take_idx;
  } ctl_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [DIV_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{(CNT_W+1-DIV_W){1'b0}}, b};
    return s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

FILE: rtl/lcfi_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on lcfi_pkg for the operand width.
module lcfi_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lcfi_pkg::DIV_W-1:0]  dividend,
  input  logic [lcfi_pkg::DIV_W-1:0]  divisor,
  output logic [lcfi_pkg::DIV_W-1:0]  quo,
  output logic                        done
);
  localparam int W = lcfi_pkg::DIV_W;

  logic [W-1:0] rem_r, q_r, dsr_r;
  logic [$clog2(W)-1:0] cnt_r;
  logic busy_r, done_r;
  logic [W:0] sh, diff;
  logic ge;

  always_comb begin
    sh = {rem_r, q_r[W-1]};
    diff = sh - {1'b0, dsr_r};
    ge = sh >= {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r <= '0;
      rem_r <= '0;
      q_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[W-1:0] : sh[W-1:0];
      q_r <= {q_r[W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == {$clog2(W){1'b1}}) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign quo = q_r;
  assign done = done_r;
endmodule

FILE: rtl/lcfi_cell.sv
// One table slot of the frequent-item chain: holds a key and count and passes a token on.
// Depends on lcfi_pkg for the token and broadcast control types.
module lcfi_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lcfi_pkg::IDX_W-1:0]  idx,
  input  lcfi_pkg::ctl_t              ctl,
  input  lcfi_pkg::tok_t              tok_in,
  output lcfi_pkg::tok_t              tok_out
);
  logic valid_r, hit_r, free_r, taken_r;
  logic [lcfi_pkg::KEY_W-1:0] key_r;
  logic [lcfi_pkg::CNT_W-1:0] cnt_r;
  lcfi_pkg::tok_t t, tok_r;
  logic hit_set, free_set;

  always_comb begin
    t = tok_in;
    hit_set = 1'b0;
    free_set = 1'b0;
    if (tok_in.act) begin
      if (tok_in.mode == lcfi_pkg::MODE_LOOKUP) begin
        if (valid_r) begin
          if (!tok_in.found && key_r == tok_in.key) begin
            t.found = 1'b1;
            t.cnt = cnt_r;
            hit_set = 1'b1;
          end
        end else if (!tok_in.free_seen) begin
          t.free_seen = 1'b1;
          free_set = 1'b1;
        end
      end else if (valid_r && !taken_r &&
                   (!tok_in.found || cnt_r > tok_in.cnt ||
                    (cnt_r == tok_in.cnt && key_r < tok_in.key))) begin
        t.found = 1'b1;
        t.cnt = cnt_r;
        t.key = key_r;
        t.idx = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r <= 1'b0;
      free_r <= 1'b0;
      taken_r <= 1'b0;
      tok_r.act <= 1'b0;
    end else begin
      tok_r <= t;
      if (ctl.clr) begin
        hit_r <= 1'b0;
        free_r <= 1'b0;
        taken_r <= 1'b0;
      end
      if (hit_set) hit_r <= 1'b1;
      if (free_set) free_r <= 1'b1;
      if (ctl.wr_hit && hit_r) cnt_r <= ctl.wcnt;
      if (ctl.wr_new && free_r) begin
        valid_r <= 1'b1;
        key_r <= ctl.wkey;
        cnt_r <= ctl.wcnt;
      end
      if (ctl.prune && valid_r &&
          cnt_r < {{(lcfi_pkg::CNT_W-lcfi_pkg::DIV_W){1'b0}}, ctl.delta}) begin
        valid_r <= 1'b0;
      end
      if (ctl.take && idx == ctl.take_idx) taken_r <= 1'b1;
    end
  end

  assign tok_out = tok_r;
endmodule

FILE: rtl/lossy_counting_frequent_items.sv
// Top level of the lossy counting frequent-item table.
// Depends on lcfi_pkg, lcfi_div and lcfi_cell.
//
// Usage: the input channel (in_valid, in_stall) takes one word per command:
// an insert (command 0) or a report (command 1). The result channel
// (out_valid, out_stall) gives one word per insert and one to 64 words per
// report, the final one marked by out_last. The window register is to be
// written through cfg_wr_en and cfg_wr_data only while the block is idle;
// the block itself does not enforce this. On an insert the key lookup, the
// longer path, travels the 64-cell chain while the two serial 32-step
// divisions for delta and future run beside it. Once all three are done the
// slot is written and the result word registered together; the table is
// then pruned if delta has changed, and the word is handed off.
// A report makes one chain pass per returned entry.
// The block works on one word at a time and holds in_stall high until the
// last result of the current word has been taken.
// Reset clears every slot and the last delta, and sets the window to 1000.
// While out_stall is high the result word is held unchanged.
module lossy_counting_frequent_items (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_stream_position,
  input  logic [63:0] in_item_key,
  input  logic [31:0] in_item_amount,
  input  logic [30:0] in_pending_sum,
  input  logic [6:0]  in_report_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_entry_key,
  output logic [47:0] out_entry_count,
  output logic        out_entry_valid,
  output logic [2:0]  out_status,
  output logic        out_last
);
  localparam int N = lcfi_pkg::TABLE_ENTRIES;
  localparam int CW = lcfi_pkg::CNT_W;
  localparam int DW = lcfi_pkg::DIV_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DIV    = 7'b0000010,
    S_PRUNE  = 7'b0000100,
    S_ROUT   = 7'b0001000,
    S_RINJ   = 7'b0010000,
    S_RWAIT  = 7'b0100000,
    S_RFLUSH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt, after_r;
  logic [DW-1:0] window_r, last_delta_r, amt_r, divisor;
  logic [63:0] key_r;
  logic [6:0] want_r, n_r, want_in;
  lcfi_pkg::tok_t fin_r, inj;
  logic fin_v_r, pend_v_r;
  logic [63:0] pend_key_r;
  logic [CW-1:0] pend_cnt_r;
  lcfi_pkg::ctl_t ctl;
  lcfi_pkg::tok_t chain [0:N];
  logic accept, div_start, div_done_a, div_done_b;
  logic [DW-1:0] delta, future, sum_pos;
  logic [DW:0] thr;
  logic [CW-1:0] dec_cnt;
  logic [2:0] dec_status;
  logic dec_valid, emit_last_pass;

  logic out_v_r, out_ev_r, out_last_r;
  logic [63:0] out_key_r;
  logic [CW-1:0] out_cnt_r;
  logic [2:0] out_st_r;

  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign divisor = (window_r == '0) ? {{(DW-1){1'b0}}, 1'b1} : window_r;
  assign sum_pos = in_stream_position + {1'b0, in_pending_sum};
  assign want_in = (in_report_count > 7'(lcfi_pkg::MAX_RESULTS)) ?
                   7'(lcfi_pkg::MAX_RESULTS) : in_report_count;
  assign div_start = accept && !in_command;

  lcfi_div u_div_delta (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(in_stream_position),
    .divisor(divisor), .quo(delta), .done(div_done_a)
  );

  lcfi_div u_div_future (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_pos),
    .divisor(divisor), .quo(future), .done(div_done_b)
  );

  assign chain[0] = inj;

  for (genvar g = 0; g < N; g++) begin : g_cell
    lcfi_cell u_cell (
      .clk(clk), .rst_n(rst_n), .idx(lcfi_pkg::IDX_W'(g)), .ctl(ctl),
      .tok_in(chain[g]), .tok_out(chain[g+1])
    );
  end

  always_comb begin
    thr = {1'b0, amt_r} + {1'b0, delta};
    dec_cnt = '0;
    dec_valid = 1'b0;
    if (fin_r.found) begin
      dec_cnt = lcfi_pkg::sat_add(fin_r.cnt, amt_r);
      dec_valid = 1'b1;
      dec_status = lcfi_pkg::ST_UPDATED;
    end else if (thr > {1'b0, future}) begin
      if (fin_r.free_seen) begin
        dec_cnt = lcfi_pkg::sat_add({{(CW-DW){1'b0}}, delta}, amt_r);
        dec_valid = 1'b1;
        dec_status = lcfi_pkg::ST_ADMITTED;
      end else begin
        dec_status = lcfi_pkg::ST_FULL;
      end
    end else begin
      dec_status = lcfi_pkg::ST_REJECTED;
    end
  end

  assign emit_last_pass = (n_r + 7'd1 == want_r);

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    ctl.wkey = key_r;
    ctl.wcnt = dec_cnt;
    ctl.delta = delta;
    ctl.take_idx = fin_r.idx;
    inj = '0;
    inj.key = in_item_key;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ctl.clr = 1'b1;
          if (!in_command) begin
            inj.act = 1'b1;
            inj.mode = lcfi_pkg::MODE_LOOKUP;
            state_nxt = S_DIV;
          end else if (want_in == '0) begin
            state_nxt = S_ROUT;
          end else begin
            state_nxt = S_RINJ;
          end
        end
      end
      S_DIV: begin
        if (div_done_a && div_done_b && fin_v_r) begin
          ctl.wr_hit = fin_r.found;
          ctl.wr_new = !fin_r.found && dec_status == lcfi_pkg::ST_ADMITTED;
          state_nxt = S_PRUNE;
        end
      end
      S_PRUNE: begin
        ctl.prune = (delta != last_delta_r);
        state_nxt = S_ROUT;
      end
      S_ROUT: begin
        if (!out_v_r || !out_stall) state_nxt = after_r;
      end
      S_RINJ: begin
        inj.act = 1'b1;
        inj.mode = lcfi_pkg::MODE_SELECT;
        state_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        if (fin_v_r) begin
          if (fin_r.found) begin
            ctl.take = 1'b1;
            if (pend_v_r) state_nxt = S_ROUT;
            else if (emit_last_pass) state_nxt = S_RFLUSH;
            else state_nxt = S_RINJ;
          end else begin
            state_nxt = S_ROUT;
          end
        end
      end
      S_RFLUSH: begin
        state_nxt = S_ROUT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      after_r <= S_IDLE;
      window_r <= lcfi_pkg::WINDOW_RESET;
      last_delta_r <= '0;
      fin_v_r <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r <= 1'b0;
      n_r <= '0;
      want_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) window_r <= cfg_wr_data;
      if (out_v_r && !out_stall) out_v_r <= 1'b0;
      if (inj.act) fin_v_r <= 1'b0;
      else if (chain[N].act) begin
        fin_v_r <= 1'b1;
        fin_r <= chain[N];
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            key_r <= in_item_key;
            amt_r <= in_item_amount;
            want_r <= want_in;
            n_r <= '0;
            pend_v_r <= 1'b0;
            after_r <= S_IDLE;
            if (in_command && want_in == '0) begin
              out_v_r <= 1'b1;
              out_key_r <= '0;
              out_cnt_r <= '0;
              out_ev_r <= 1'b0;
              out_st_r <= lcfi_pkg::ST_REPORT;
              out_last_r <= 1'b1;
            end
          end
        end
        S_DIV: begin
          if (state_nxt == S_PRUNE) begin
            out_v_r <= 1'b1;
            out_key_r <= key_r;
            out_cnt_r <= dec_cnt;
            out_ev_r <= dec_valid;
            out_st_r <= dec_status;
            out_last_r <= 1'b1;
          end
        end
        S_PRUNE: begin
          last_delta_r <= delta;
          after_r <= S_IDLE;
        end
        S_RWAIT: begin
          if (fin_v_r) begin
            if (fin_r.found) begin
              pend_v_r <= 1'b1;
              pend_key_r <= fin_r.key;
              pend_cnt_r <= fin_r.cnt;
              n_r <= n_r + 7'd1;
              after_r <= emit_last_pass ? S_RFLUSH : S_RINJ;
              if (pend_v_r) begin
                out_v_r <= 1'b1;
                out_key_r <= pend_key_r;
                out_cnt_r <= pend_cnt_r;
                out_ev_r <= 1'b1;
                out_st_r <= lcfi_pkg::ST_REPORT;
                out_last_r <= 1'b0;
              end
            end else begin
              after_r <= S_IDLE;
              out_v_r <= 1'b1;
              out_key_r <= pend_v_r ? pend_key_r : '0;
              out_cnt_r <= pend_v_r ? pend_cnt_r : '0;
              out_ev_r <= pend_v_r;
              out_st_r <= lcfi_pkg::ST_REPORT;
              out_last_r <= 1'b1;
            end
          end
        end
        S_RFLUSH: begin
          after_r <= S_IDLE;
          out_v_r <= 1'b1;
          out_key_r <= pend_key_r;
          out_cnt_r <= pend_cnt_r;
          out_ev_r <= 1'b1;
          out_st_r <= lcfi_pkg::ST_REPORT;
          out_last_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_v_r;
  assign out_entry_key = out_key_r;
  assign out_entry_count = out_cnt_r;
  assign out_entry_valid = out_ev_r;
  assign out_status = out_st_r;
  assign out_last = out_last_r;

`ifndef SYNTHESIS
  a_out_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> state_r != S_IDLE)
    else $error("result word pending while idle");
  a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input not stalled after accept");
  a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.wr_hit && ctl.wr_new))
    else $error("update and admission in the same cycle");
  a_report_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= 7'(lcfi_pkg::MAX_RESULTS))
    else $error("report returned too many words");
`endif
endmodule

FILE: bench/lossy_counting_frequent_items_tb.sv
// Self-checking testbench for lossy_counting_frequent_items: directed table, then random words.
// Depends on lcfi_pkg and the lossy_counting_frequent_items RTL; has its own table predictor.
`timescale 1ns / 1ps

module lossy_counting_frequent_items_tb;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REPORT = 1'b1;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic        cmd;
    logic [31:0] pos;
    logic [63:0] key;
    logic [31:0] amt;
    logic [30:0] psum;
    logic [6:0]  rcnt;
  } word_t;

  typedef struct {
    logic [63:0] key;
    logic [47:0] cnt;
    logic        valid;
    logic [2:0]  status;
    logic        last;
  } result_t;

  typedef struct {
    word_t   w;
    bit      typed;
    result_t r;
  } row_t;

  logic clk, rst_n;
  logic cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic in_valid, in_stall, in_command;
  logic [31:0] in_stream_position, in_item_amount;
  logic [63:0] in_item_key;
  logic [30:0] in_pending_sum;
  logic [6:0] in_report_count;
  logic out_valid, out_stall;
  logic [63:0] out_entry_key;
  logic [47:0] out_entry_count;
  logic out_entry_valid;
  logic [2:0] out_status;
  logic out_last;

  lossy_counting_frequent_items u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_stream_position(in_stream_position), .in_item_key(in_item_key),
    .in_item_amount(in_item_amount), .in_pending_sum(in_pending_sum),
    .in_report_count(in_report_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_entry_key(out_entry_key), .out_entry_count(out_entry_count),
    .out_entry_valid(out_entry_valid), .out_status(out_status), .out_last(out_last)
  );

  logic [31:0] win_model;
  logic [63:0] tbl_key [lcfi_pkg::TABLE_ENTRIES];
  logic [47:0] tbl_cnt [lcfi_pkg::TABLE_ENTRIES];
  bit tbl_valid [lcfi_pkg::TABLE_ENTRIES];
  logic [31:0] delta_model;
  result_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 36, recv_idle_pct = 56;
  int idle_cycles = 0;
  logic [63:0] key_pool [16];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic result_t mk_res(logic [63:0] k, logic [47:0] c, logic v,
                                     logic [2:0] s, logic l);
    result_t r;
    r.key = k; r.cnt = c; r.valid = v; r.status = s; r.last = l;
    return r;
  endfunction

  function automatic void expect_add(result_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic logic [47:0] count_add(logic [47:0] a, logic [32:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {16'd0, b};
    return s[48] ? lcfi_pkg::COUNT_MAX : s[47:0];
  endfunction

  function automatic void predict_insert(word_t w);
    logic [31:0] divisor, delta, future, sum;
    int hit, free_idx;
    result_t r;
    divisor = (win_model == 0) ? 32'd1 : win_model;
    sum = w.pos + {1'b0, w.psum};
    delta = w.pos / divisor;
    future = sum / divisor;
    hit = -1;
    free_idx = -1;
    r = mk_res(w.key, '0, 1'b0, lcfi_pkg::ST_REJECTED, 1'b1);
    for (int i = 0; i < lcfi_pkg::TABLE_ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        if (hit < 0 && tbl_key[i] == w.key) hit = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (hit >= 0) begin
      tbl_cnt[hit] = count_add(tbl_cnt[hit], {1'b0, w.amt});
      r = mk_res(w.key, tbl_cnt[hit], 1'b1, lcfi_pkg::ST_UPDATED, 1'b1);
    end else if (({1'b0, w.amt} + {1'b0, delta}) > {1'b0, future}) begin
      if (free_idx >= 0) begin
        tbl_valid[free_idx] = 1'b1;
        tbl_key[free_idx] = w.key;
        tbl_cnt[free_idx] = count_add({16'd0, delta}, {1'b0, w.amt});
        r = mk_res(w.key, tbl_cnt[free_idx], 1'b1, lcfi_pkg::ST_ADMITTED, 1'b1);
      end else begin
        r.status = lcfi_pkg::ST_FULL;
      end
    end
    if (delta_model != delta) begin
      delta_model = delta;
      for (int i = 0; i < lcfi_pkg::TABLE_ENTRIES; i++)
        if (tbl_valid[i] && tbl_cnt[i] < {16'd0, delta}) tbl_valid[i] = 1'b0;
    end
    expect_add(r);
  endfunction

  function automatic void predict_report(word_t w);
    bit taken [lcfi_pkg::TABLE_ENTRIES];
    int want, n, best;
    want = (w.rcnt > lcfi_pkg::MAX_RESULTS) ? lcfi_pkg::MAX_RESULTS : w.rcnt;
    n = 0;
    for (int i = 0; i < lcfi_pkg::TABLE_ENTRIES; i++) taken[i] = 1'b0;
    while (n < want) begin
      best = -1;
      for (int i = 0; i < lcfi_pkg::TABLE_ENTRIES; i++) begin
        if (tbl_valid[i] && !taken[i]) begin
          if (best < 0 || tbl_cnt[i] > tbl_cnt[best] ||
              (tbl_cnt[i] == tbl_cnt[best] && tbl_key[i] < tbl_key[best]))
            best = i;
        end
      end
      if (best < 0) break;
      taken[best] = 1'b1;
      expect_add(mk_res(tbl_key[best], tbl_cnt[best], 1'b1, lcfi_pkg::ST_REPORT, 1'b0));
      n++;
    end
    if (n == 0) expect_add(mk_res('0, '0, 1'b0, lcfi_pkg::ST_REPORT, 1'b1));
    else pending_results[pending_results.size()-1].last = 1'b1;
  endfunction

  function automatic void predict_word(word_t w);
    if (w.cmd == CMD_INSERT) predict_insert(w);
    else predict_report(w);
  endfunction

  task automatic send_word(word_t w, bit typed, result_t r);
    int depth;
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_command <= w.cmd;
    in_stream_position <= w.pos;
    in_item_key <= w.key;
    in_item_amount <= w.amt;
    in_pending_sum <= w.psum;
    in_report_count <= w.rcnt;
    do @(posedge clk); while (in_stall);
    depth = pending_results.size();
    predict_word(w);
    if (typed) begin
      while (pending_results.size() > depth) void'(pending_results.pop_back());
      expect_add(r);
    end
  endtask

  task automatic write_window(logic [31:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    win_model = value;
  endtask

  function automatic word_t rand_word(int style);
    word_t w;
    w.cmd = ($urandom_range(99) < 15) ? CMD_REPORT : CMD_INSERT;
    w.pos = $urandom();
    w.key = {$urandom(), $urandom()};
    w.amt = $urandom();
    w.psum = 31'($urandom());
    case ($urandom_range(9))
      0: w.rcnt = 7'h7f;
      1: w.rcnt = 7'($urandom());
      default: w.rcnt = 7'($urandom_range(8));
    endcase
    if (style == 0) begin
      w.key = key_pool[$urandom_range(15)];
      w.pos = $urandom_range(60);
      w.amt = $urandom_range(30);
      w.psum = 31'($urandom_range(20));
    end else if (style == 1) begin
      w.pos = $urandom_range(100);
      w.amt = $urandom_range(1, 50);
      w.psum = 31'($urandom_range(100));
    end else if (style == 2) begin
      if ($urandom_range(3) != 0) w.key = key_pool[$urandom_range(15)];
      w.pos = $urandom_range(400);
      w.amt = $urandom_range(40);
      w.psum = 31'($urandom_range(30));
    end else if ($urandom_range(1)) begin
      w.key = key_pool[$urandom_range(15)];
    end
    return w;
  endfunction

  task automatic run_random(int n, int style);
    result_t none;
    none = mk_res('0, '0, 1'b0, lcfi_pkg::ST_REPORT, 1'b0);
    for (int i = 0; i < n; i++) send_word(rand_word(style), 1'b0, none);
  endtask

  function automatic row_t mk_row(logic cmd, logic [31:0] pos, logic [63:0] key,
                                  logic [31:0] amt, logic [30:0] psum, logic [6:0] rcnt,
                                  bit typed, result_t r);
    row_t row;
    row.w.cmd = cmd; row.w.pos = pos; row.w.key = key; row.w.amt = amt;
    row.w.psum = psum; row.w.rcnt = rcnt; row.typed = typed; row.r = r;
    return row;
  endfunction

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word key=%h count=%h valid=%b status=%0d last=%b",
                 $time, out_entry_key, out_entry_count, out_entry_valid, out_status,
                 out_last);
        errors++;
      end else begin
        result_t e;
        e = pending_results.pop_front();
        if (out_entry_key !== e.key || out_entry_count !== e.cnt ||
            out_entry_valid !== e.valid || out_status !== e.status || out_last !== e.last) begin
          $display("%0t: mismatch expected key=%h count=%h valid=%b status=%0d last=%b",
                   $time, e.key, e.cnt, e.valid, e.status, e.last);
          $display("%0t:          actual   key=%h count=%h valid=%b status=%0d last=%b",
                   $time, out_entry_key, out_entry_count, out_entry_valid, out_status,
                   out_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("lossy_counting_frequent_items_tb: errors");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    result_t none;
    none = mk_res('0, '0, 1'b0, lcfi_pkg::ST_REPORT, 1'b0);
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_command = CMD_INSERT;
    in_stream_position = '0;
    in_item_key = '0;
    in_item_amount = '0;
    in_pending_sum = '0;
    in_report_count = '0;
    win_model = lcfi_pkg::WINDOW_RESET;
    delta_model = '0;
    for (int i = 0; i < lcfi_pkg::TABLE_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0; tbl_key[i] = '0; tbl_cnt[i] = '0;
    end
    for (int i = 0; i < 16; i++) key_pool[i] = (i < 4) ? 64'(i) : {$urandom(), $urandom()};

    rows = {rows, mk_row(CMD_REPORT, 0, 0, 0, 0, 5, 1,
                         mk_res('0, '0, 1'b0, lcfi_pkg::ST_REPORT, 1'b1))};
    rows = {rows, mk_row(CMD_INSERT, 0, 0, 0, 0, 0, 1,
                         mk_res('0, '0, 1'b0, lcfi_pkg::ST_REJECTED, 1'b1))};
    rows = {rows, mk_row(CMD_INSERT, 0, '1, '1, 0, 0, 1,
                         mk_res('1, 48'hFFFF_FFFF, 1'b1, lcfi_pkg::ST_ADMITTED, 1'b1))};
    rows = {rows, mk_row(CMD_INSERT, 0, '1, 1, 0, 0, 1,
                         mk_res('1, 48'h1_0000_0000, 1'b1, lcfi_pkg::ST_UPDATED, 1'b1))};
    rows = {rows, mk_row(CMD_INSERT, 10, 5, 3, '1, 0, 1,
                         mk_res(64'd5, '0, 1'b0, lcfi_pkg::ST_REJECTED, 1'b1))};
    rows = {rows, mk_row(CMD_INSERT, 10, 5, 3, 0, 0, 0, none)};
    rows = {rows, mk_row(CMD_INSERT, 999, 6, 1, 0, 0, 0, none)};
    rows = {rows, mk_row(CMD_INSERT, 1000, 7, 2, 0, 0, 0, none)};
    rows = {rows, mk_row(CMD_INSERT, 2500, 6, 0, 0, 0, 0, none)};
    rows = {rows, mk_row(CMD_INSERT, '1, 8, 5, 1, 0, 0, none)};
    rows = {rows, mk_row(CMD_REPORT, '1, '1, '1, '1, '1, 0, none)};
    rows = {rows, mk_row(CMD_REPORT, 0, 0, 0, 0, 0, 1,
                         mk_res('0, '0, 1'b0, lcfi_pkg::ST_REPORT, 1'b1))};
    rows = {rows, mk_row(CMD_REPORT, 0, 0, 0, 0, 2, 0, none)};
    rows = {rows, mk_row(CMD_INSERT, 0, 3, '1, '1, 0, 0, none)};
    rows = {rows, mk_row(CMD_REPORT, 0, 0, 0, 0, 64, 0, none)};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].r);

    write_window(32'd0);
    run_random(80, 0);
    write_window(32'hFFFF_FFFF);
    run_random(100, 1);
    send_idle_pct = 56;
    recv_idle_pct = 36;
    write_window(32'd7);
    run_random(140, 2);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_window($urandom());
    run_random(140, 3);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) $display("lossy_counting_frequent_items_tb: clean");
    else $display("lossy_counting_frequent_items_tb: errors");
    $finish;
  end

endmodule
